@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro expects i_clk and i_rst_n
// to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define COAB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define COAB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/coab_pkg.sv @@
package coab_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    localparam logic FMT_XRGB8888 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PIXEL_FORMAT  = 2'd0;
    localparam t_cfg_idx CFG_CURSOR_ENABLE = 2'd1;
    localparam t_cfg_idx CFG_CURSOR_X      = 2'd2;
    localparam t_cfg_idx CFG_CURSOR_Y      = 2'd3;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

    // 255/31 and 255/63 folded with a reciprocal of 2^18/31 and 2^20/63.
    localparam logic [31:0] EXP5_MUL = 32'd2156535;
    localparam logic [31:0] EXP6_MUL = 32'd4244475;

    localparam logic [13:0] NARROW5_MUL = 14'd31;
    localparam logic [13:0] NARROW6_MUL = 14'd63;

    typedef logic [2:0][7:0]  t_rgb;
    typedef logic [2:0][15:0] t_rgb_sum;
    typedef logic [2:0][13:0] t_rgb_q;

    // Exact floor(x/255) for any 16-bit x below 65280.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    // floor(f*255/31)
    function automatic logic [7:0] expand5(input logic [4:0] f);
        logic [31:0] p;
        p = 32'(f) * EXP5_MUL;
        return p[25:18];
    endfunction

    // floor(f*255/63)
    function automatic logic [7:0] expand6(input logic [5:0] f);
        logic [31:0] p;
        p = 32'(f) * EXP6_MUL;
        return p[27:20];
    endfunction

endpackage

@@ rtl/core/coab_ram.sv @@
module coab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/core/cursor_overlay_alpha_blend.sv @@
// Hardware cursor overlay. Write words (opcode 0) store one RGBA texel into
// the cursor image and take effect at acceptance; they return no word.
// Blend words (opcode 1) return one pixel each, and a new word can be accepted
// every cycle unless the pipeline stalls. The pipeline has six register stages:
// window check and texel address, texel read from the image RAM, channel unpack
// and RGB565 widening, the two alpha products, the divide by 255 with RGB565
// narrowing products, and the packed output register. The whole pipeline
// stalls together when the output word is not taken. Configuration must be
// written only while no blend word is in flight; the block does not enforce it.
`include "assert_macros.svh"

module cursor_overlay_alpha_blend
    import coab_pkg::*;
#(
    parameter int CURSOR_WIDTH  = 16,
    parameter int CURSOR_HEIGHT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  logic [11:0] i_cfg_data,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic [31:0] i_dest_pixel,
    input  logic [7:0]  i_texel_index,
    input  logic [31:0] i_texel_rgba,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_pixel,
    output logic        o_was_blended
);

    localparam int DEPTH = CURSOR_WIDTH * CURSOR_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(CURSOR_WIDTH);
    localparam int RW    = $clog2(CURSOR_HEIGHT);

    // Configuration.
    logic        r_pixel_format;
    logic        r_cursor_enable;
    logic [11:0] r_cursor_x;
    logic [11:0] r_cursor_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format  <= FMT_XRGB8888;
            r_cursor_enable <= 1'b0;
            r_cursor_x      <= '0;
            r_cursor_y      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXEL_FORMAT:  r_pixel_format  <= i_cfg_data[0];
                CFG_CURSOR_ENABLE: r_cursor_enable <= i_cfg_data[0];
                CFG_CURSOR_X:      r_cursor_x      <= i_cfg_data;
                CFG_CURSOR_Y:      r_cursor_y      <= i_cfg_data;
                default:           r_cursor_enable <= r_cursor_enable;
            endcase
        end
    end

    // The whole pipeline moves when the output register is free or taken.
    logic w_adv;
    logic w_accept;

    assign w_adv    = !o_valid || i_ready;
    assign o_ready  = w_adv;
    assign w_accept = i_valid && w_adv;

    // Texel writes.
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;

    assign w_ram_we    = w_accept && (i_opcode == OP_WRITE) &&
                         (32'(i_texel_index) < 32'(DEPTH));
    assign w_ram_waddr = AW'(i_texel_index);

    // Stage 1: window test and texel address.
    logic [12:0]   n_dx;
    logic [12:0]   n_dy;
    logic          n_hit;
    logic [AW-1:0] n_addr;

    assign n_dx  = {1'b0, i_pixel_x} - {1'b0, r_cursor_x};
    assign n_dy  = {1'b0, i_pixel_y} - {1'b0, r_cursor_y};
    assign n_hit = r_cursor_enable && !n_dx[12] && !n_dy[12] &&
                   (32'(n_dx[11:0]) < 32'(CURSOR_WIDTH)) &&
                   (32'(n_dy[11:0]) < 32'(CURSOR_HEIGHT));
    assign n_addr = AW'(AW'(n_dy[RW-1:0]) * AW'(CURSOR_WIDTH)) + AW'(n_dx[CW-1:0]);

    logic          r_v1;
    logic          r_hit1;
    logic [31:0]   r_dest1;
    logic [AW-1:0] r_addr1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid && (i_opcode == OP_BLEND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit1  <= n_hit;
            r_dest1 <= i_dest_pixel;
            r_addr1 <= n_addr;
        end
    end

    // Stage 2: texel comes out of the RAM.
    logic [31:0] w_texel;

    coab_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (i_texel_rgba),
        .i_re    (w_adv),
        .i_raddr (r_addr1),
        .o_rdata (w_texel)
    );

    logic        r_v2;
    logic        r_hit2;
    logic [31:0] r_dest2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit2  <= r_hit1;
            r_dest2 <= r_dest1;
        end
    end

    // Unpack source and destination channels.
    t_rgb n_src;
    t_rgb n_dst;

    always_comb begin
        n_src[CH_R] = w_texel[7:0];
        n_src[CH_G] = w_texel[15:8];
        n_src[CH_B] = w_texel[23:16];
        if (r_pixel_format == FMT_RGB565) begin
            n_dst[CH_R] = expand5(r_dest2[15:11]);
            n_dst[CH_G] = expand6(r_dest2[10:5]);
            n_dst[CH_B] = expand5(r_dest2[4:0]);
        end else begin
            n_dst[CH_R] = r_dest2[23:16];
            n_dst[CH_G] = r_dest2[15:8];
            n_dst[CH_B] = r_dest2[7:0];
        end
    end

    // Stage 3.
    logic        r_v3;
    logic        r_blend3;
    logic [31:0] r_dest3;
    t_rgb        r_src3;
    t_rgb        r_dst3;
    logic [7:0]  r_alpha3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_blend3 <= r_hit2 && (w_texel[31:24] != 8'd0);
            r_dest3  <= r_dest2;
            r_src3   <= n_src;
            r_dst3   <= n_dst;
            r_alpha3 <= w_texel[31:24];
        end
    end

    // Weighted sum s*a + d*(255-a) for each channel.
    t_rgb_sum   n_sum;
    logic [7:0] w_inv_alpha;

    assign w_inv_alpha = ALPHA_MAX - r_alpha3;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = 16'(r_src3[c]) * 16'(r_alpha3) + 16'(r_dst3[c]) * 16'(w_inv_alpha);
        end
    end

    // Stage 4.
    logic        r_v4;
    logic        r_blend4;
    logic [31:0] r_dest4;
    t_rgb_sum    r_sum4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_blend4 <= r_blend3;
            r_dest4  <= r_dest3;
            r_sum4   <= n_sum;
        end
    end

    // Divide by 255; in RGB565 mode also start narrowing with the 31 or 63 product.
    t_rgb_q n_q;

    always_comb begin
        logic [7:0] m;
        for (int c = 0; c < 3; c++) begin
            m = div255(r_sum4[c]);
            if (r_pixel_format == FMT_RGB565) begin
                n_q[c] = 14'(m) * ((c == CH_G) ? NARROW6_MUL : NARROW5_MUL);
            end else begin
                n_q[c] = 14'(m);
            end
        end
    end

    // Stage 5.
    logic        r_v5;
    logic        r_blend5;
    logic [31:0] r_dest5;
    t_rgb_q      r_q5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_blend5 <= r_blend4;
            r_dest5  <= r_dest4;
            r_q5     <= n_q;
        end
    end

    // Pack the result.
    logic [31:0] n_pixel;
    logic [7:0]  w_nr;
    logic [7:0]  w_ng;
    logic [7:0]  w_nb;

    assign w_nr = div255(16'(r_q5[CH_R]));
    assign w_ng = div255(16'(r_q5[CH_G]));
    assign w_nb = div255(16'(r_q5[CH_B]));

    always_comb begin
        if (!r_blend5) begin
            n_pixel = r_dest5;
        end else if (r_pixel_format == FMT_RGB565) begin
            n_pixel = {16'd0, w_nr[4:0], w_ng[5:0], w_nb[4:0]};
        end else begin
            n_pixel = {8'd0, r_q5[CH_R][7:0], r_q5[CH_G][7:0], r_q5[CH_B][7:0]};
        end
    end

    // Stage 6: output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_pixel   <= n_pixel;
            o_was_blended <= r_blend5;
        end
    end

    `COAB_ASSERT(a_stall_holds, !w_adv |=> ($stable(r_v1) && $stable(r_v3) && $stable(r_v5)),
        "pipeline moved during a stall")
    `COAB_NEVER(a_blend_needs_enable, r_v3 && r_blend3 && !r_cursor_enable,
        "blend marked while the cursor is disabled")
    `COAB_ASSERT(a_blend_top_zero, (o_valid && o_was_blended) |->
        (o_out_pixel[31:24] == 8'd0 &&
         (r_pixel_format == FMT_XRGB8888 || o_out_pixel[31:16] == 16'd0)),
        "blended pixel has nonzero unused bits")

endmodule

@@ dv/cursor_overlay_alpha_blend_test.sv @@
`timescale 1ns / 100ps

module cursor_overlay_alpha_blend_test;
    import coab_pkg::*;

    localparam int CUR_W           = 16;
    localparam int CUR_H           = 16;
    localparam int TEXELS          = CUR_W * CUR_H;
    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int MAX_REPORTS     = 40;

    typedef struct {
        logic        is_reg;
        t_cfg_idx    reg_idx;
        logic [11:0] reg_val;
        logic        op;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] dest;
        logic [7:0]  tidx;
        logic [31:0] rgba;
        logic        known;
        logic [31:0] known_pix;
        logic        known_bl;
    } t_row;

    typedef struct {
        logic [31:0] pix;
        logic        bl;
    } t_pixel_exp;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    t_cfg_idx    i_cfg_index   = CFG_PIXEL_FORMAT;
    logic [11:0] i_cfg_data    = '0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic        i_opcode      = OP_WRITE;
    logic [11:0] i_pixel_x     = '0;
    logic [11:0] i_pixel_y     = '0;
    logic [31:0] i_dest_pixel  = '0;
    logic [7:0]  i_texel_index = '0;
    logic [31:0] i_texel_rgba  = '0;
    logic        o_valid;
    logic        i_ready       = 1'b1;
    logic [31:0] o_out_pixel;
    logic        o_was_blended;

    // Hand-derived expectation that travels with the word on offer.
    logic        word_known     = 1'b0;
    logic [31:0] word_known_pix = '0;
    logic        word_known_bl  = 1'b0;

    logic        idle_on         = 1'b0;
    int unsigned stall_left      = 0;
    int unsigned cycle_count     = 0;
    int unsigned error_count     = 0;
    int unsigned texel_writes    = 0;
    int unsigned pixels_seen     = 0;
    int unsigned pixels_modified = 0;
    int unsigned settings_used   = 0;

    // Shadow copy of the overlay registers and the cursor image.
    logic        shadow_fmt = FMT_XRGB8888;
    logic        shadow_en  = 1'b0;
    logic [11:0] shadow_cx  = '0;
    logic [11:0] shadow_cy  = '0;
    logic [31:0] shadow_image [TEXELS];
    t_pixel_exp  pixel_q [$];

    cursor_overlay_alpha_blend dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_dest_pixel  (i_dest_pixel),
        .i_texel_index (i_texel_index),
        .i_texel_rgba  (i_texel_rgba),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_pixel   (o_out_pixel),
        .o_was_blended (o_was_blended)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned alpha_mix(input int unsigned s, input int unsigned d,
                                              input int unsigned a);
        return (s * a + d * (255 - a)) / 255;
    endfunction

    function automatic void predict_pixel(input logic [11:0] px, input logic [11:0] py,
                                          input logic [31:0] dest,
                                          output logic [31:0] pix, output logic bl);
        int unsigned dx, dy, a;
        int unsigned dr, dg, db, r, g, b;
        logic [31:0] tex;
        pix = dest;
        bl  = 1'b0;
        if (!shadow_en || px < shadow_cx || py < shadow_cy) return;
        dx = px - shadow_cx;
        dy = py - shadow_cy;
        if (dx >= CUR_W || dy >= CUR_H) return;
        tex = shadow_image[dy * CUR_W + dx];
        a   = tex[31:24];
        if (a == 0) return;
        if (shadow_fmt == FMT_XRGB8888) begin
            r   = alpha_mix(tex[7:0], dest[23:16], a);
            g   = alpha_mix(tex[15:8], dest[15:8], a);
            b   = alpha_mix(tex[23:16], dest[7:0], a);
            pix = {8'h00, 8'(r), 8'(g), 8'(b)};
        end else begin
            // RGB565 fields are widened to 8 bits, blended, then narrowed again.
            dr  = dest[15:11] * 255 / 31;
            dg  = dest[10:5] * 255 / 63;
            db  = dest[4:0] * 255 / 31;
            r   = alpha_mix(tex[7:0], dr, a) * 31 / 255;
            g   = alpha_mix(tex[15:8], dg, a) * 63 / 255;
            b   = alpha_mix(tex[23:16], db, a) * 31 / 255;
            pix = {16'h0000, 5'(r), 6'(g), 5'(b)};
        end
        bl = 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_pixel_exp  want;
        logic [31:0] pix;
        logic        bl;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIXEL_FORMAT:  shadow_fmt = i_cfg_data[0];
                    CFG_CURSOR_ENABLE: shadow_en  = i_cfg_data[0];
                    CFG_CURSOR_X:      shadow_cx  = i_cfg_data;
                    CFG_CURSOR_Y:      shadow_cy  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                if (i_opcode == OP_WRITE) begin
                    shadow_image[i_texel_index] = i_texel_rgba;
                    texel_writes++;
                end else begin
                    predict_pixel(i_pixel_x, i_pixel_y, i_dest_pixel, pix, bl);
                    if (word_known) begin
                        pix = word_known_pix;
                        bl  = word_known_bl;
                    end
                    pixel_q.push_back('{pix, bl});
                end
            end
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    flag_error($sformatf("pixel %h arrived with nothing pending", o_out_pixel));
                end else begin
                    want = pixel_q.pop_front();
                    pixels_seen++;
                    if (want.bl) pixels_modified++;
                    if (o_out_pixel !== want.pix)
                        flag_error($sformatf("out_pixel %h, expected %h", o_out_pixel, want.pix));
                    if (o_was_blended !== want.bl)
                        flag_error($sformatf("was_blended %b, expected %b",
                                             o_was_blended, want.bl));
                end
            end
        end
    end

    // Output back-pressure in bursts of random length.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_ready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 11);
            i_ready    <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d pixels pending",
                     cycle_count, pixel_q.size());
            $display("cursor_overlay_alpha_blend regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] texel_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v[31:24] = 8'h00;
            1: v[31:24] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] dest_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] corner_coord();
        case ($urandom_range(0, 4))
            0: return 12'd0;
            1: return 12'd4095;
            2: return 12'd4080;
            default: return 12'($urandom);
        endcase
    endfunction

    // Fields that the opcode does not use still carry random values.
    function automatic t_row noise_row();
        t_row r;
        r.is_reg    = 1'b0;
        r.reg_idx   = CFG_PIXEL_FORMAT;
        r.reg_val   = '0;
        r.op        = OP_BLEND;
        r.px        = 12'($urandom);
        r.py        = 12'($urandom);
        r.dest      = $urandom;
        r.tidx      = 8'($urandom);
        r.rgba      = $urandom;
        r.known     = 1'b0;
        r.known_pix = '0;
        r.known_bl  = 1'b0;
        return r;
    endfunction

    function automatic t_row reg_row(input t_cfg_idx idx, input logic [11:0] val);
        t_row r;
        r         = noise_row();
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row texel_row(input logic [7:0] idx, input logic [31:0] rgba);
        t_row r;
        r      = noise_row();
        r.op   = OP_WRITE;
        r.tidx = idx;
        r.rgba = rgba;
        return r;
    endfunction

    function automatic t_row blend_row(input logic [11:0] px, input logic [11:0] py,
                                       input logic [31:0] dest);
        t_row r;
        r      = noise_row();
        r.px   = px;
        r.py   = py;
        r.dest = dest;
        return r;
    endfunction

    function automatic t_row known_row(input logic [11:0] px, input logic [11:0] py,
                                       input logic [31:0] dest, input logic [31:0] pix,
                                       input logic bl);
        t_row r;
        r           = blend_row(px, py, dest);
        r.known     = 1'b1;
        r.known_pix = pix;
        r.known_bl  = bl;
        return r;
    endfunction

    // Mostly pixels inside the cursor window, some on its border band, a few anywhere.
    function automatic t_row random_word(input logic [11:0] base_x, input logic [11:0] base_y);
        t_row r;
        r = noise_row();
        if ($urandom_range(0, 7) == 0) begin
            r.op   = OP_WRITE;
            r.rgba = texel_value();
            return r;
        end
        case ($urandom_range(0, 9))
            0: ;
            1, 2: begin
                r.px = base_x + 12'($urandom_range(0, CUR_W + 1)) - 12'd1;
                r.py = base_y + 12'($urandom_range(0, CUR_H + 1)) - 12'd1;
            end
            default: begin
                r.px = base_x + 12'($urandom_range(0, CUR_W - 1));
                r.py = base_y + 12'($urandom_range(0, CUR_H - 1));
            end
        endcase
        r.dest = dest_value();
        return r;
    endfunction

    task automatic offer_row(input t_row r);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= r.op;
        i_pixel_x      <= r.px;
        i_pixel_y      <= r.py;
        i_dest_pixel   <= r.dest;
        i_texel_index  <= r.tidx;
        i_texel_rgba   <= r.rgba;
        word_known     <= r.known;
        word_known_pix <= r.known_pix;
        word_known_bl  <= r.known_bl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [11:0] val, input bit last);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (last) i_cfg_we <= 1'b0;
    endtask

    // Let every pending pixel out, then give texel writes time to land. The first
    // edge lets the scoreboard record the word that was accepted just before.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_row        plan [$];
        logic [11:0] base_x;
        logic [11:0] base_y;

        // Cursor disabled after reset: everything passes through.
        plan.push_back(known_row(12'd0, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(known_row(12'd4095, 12'd4095, 32'h0000_0000, 32'h0000_0000, 1'b0));
        plan.push_back(texel_row(8'd0, 32'hFF00_00FF));
        plan.push_back(texel_row(8'd15, 32'hFFFF_FFFF));
        plan.push_back(texel_row(8'd17, 32'h8056_3412));
        plan.push_back(texel_row(8'd240, 32'h0100_0000));
        plan.push_back(texel_row(8'd255, 32'h00FF_FFFF));
        plan.push_back(reg_row(CFG_CURSOR_ENABLE, 12'd1));
        plan.push_back(known_row(12'd0, 12'd0, 32'h1234_5678, 32'h00FF_0000, 1'b1));
        plan.push_back(known_row(12'd15, 12'd0, 32'h0000_0000, 32'h00FF_FFFF, 1'b1));
        plan.push_back(known_row(12'd15, 12'd15, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b0));
        plan.push_back(blend_row(12'd0, 12'd15, 32'hFF80_8080));
        plan.push_back(blend_row(12'd1, 12'd1, 32'h00FF_FFFF));
        plan.push_back(known_row(12'd16, 12'd0, 32'hCAFE_F00D, 32'hCAFE_F00D, 1'b0));
        plan.push_back(known_row(12'd0, 12'd16, 32'h0BAD_F00D, 32'h0BAD_F00D, 1'b0));
        plan.push_back(reg_row(CFG_PIXEL_FORMAT, 12'd1));
        plan.push_back(known_row(12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0000_F800, 1'b1));
        plan.push_back(known_row(12'd15, 12'd0, 32'hABCD_0000, 32'h0000_FFFF, 1'b1));
        plan.push_back(blend_row(12'd1, 12'd1, 32'h0000_FFFF));
        plan.push_back(blend_row(12'd0, 12'd15, 32'hFFFF_07E0));
        plan.push_back(known_row(12'd15, 12'd15, 32'h1234_5678, 32'h1234_5678, 1'b0));
        // Window pushed against the bottom-right screen corner.
        plan.push_back(reg_row(CFG_CURSOR_X, 12'd4080));
        plan.push_back(reg_row(CFG_CURSOR_Y, 12'd4080));
        plan.push_back(known_row(12'd4080, 12'd4080, 32'h0000_0000, 32'h0000_F800, 1'b1));
        plan.push_back(known_row(12'd4095, 12'd4080, 32'h5555_5555, 32'h0000_FFFF, 1'b1));
        plan.push_back(known_row(12'd4079, 12'd4080, 32'h7777_7777, 32'h7777_7777, 1'b0));
        plan.push_back(known_row(12'd0, 12'd0, 32'h8888_8888, 32'h8888_8888, 1'b0));
        plan.push_back(reg_row(CFG_CURSOR_ENABLE, 12'd0));
        plan.push_back(known_row(12'd4080, 12'd4080, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (i == 0 || !plan[i - 1].is_reg) begin
                    settle();
                    settings_used++;
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val,
                          i == plan.size() - 1 || !plan[i + 1].is_reg);
            end else begin
                offer_row(plan[i]);
            end
        end

        // Load the whole image so that no later window read hits an empty texel.
        for (int t = 0; t < TEXELS; t++) offer_row(texel_row(8'(t), texel_value()));

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            base_x  = corner_coord();
            base_y  = corner_coord();
            idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            write_reg(CFG_PIXEL_FORMAT, 12'(ph % 2), 1'b0);
            write_reg(CFG_CURSOR_ENABLE, 12'($urandom_range(0, 5) != 0), 1'b0);
            write_reg(CFG_CURSOR_X, base_x, 1'b0);
            write_reg(CFG_CURSOR_Y, base_y, 1'b1);
            settings_used++;
            repeat (WORDS_PER_PHASE) offer_row(random_word(base_x, base_y));
        end
        settle();

        $display("%0d texel writes and %0d pixels checked, %0d of them blended,",
                 texel_writes, pixels_seen, pixels_modified);
        $display("over %0d cursor settings in both pixel formats", settings_used);
        if (error_count == 0) begin
            $display("cursor_overlay_alpha_blend regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("cursor_overlay_alpha_blend regression: fail");
        end
        $finish;
    end

endmodule
